### src/cept_pkg.sv
`timescale 1ns / 1ps

package cept_pkg;

  typedef enum logic [2:0] {
    OP_PUT        = 3'd0,
    OP_TAKE       = 3'd1,
    OP_DROP_EXACT = 3'd2,
    OP_DROP_SLOT  = 3'd3,
    OP_CLEAR      = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    OUT_NONE         = 2'd0,
    OUT_MATCHED      = 2'd1,
    OUT_STORED_FREE  = 2'd2,
    OUT_STORED_EVICT = 2'd3
  } outcome_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic [7:0]  slot;
    logic [4:0]  endpoint;
    logic [63:0] trb;
    logic [7:0]  code;
    logic [23:0] residue;
  } entry_t;

  typedef struct packed {
    outcome_t    outcome;
    logic [7:0]  found_code;
    logic [23:0] found_residue;
  } result_t;

endpackage

### src/cept_store.sv
`timescale 1ns / 1ps

module cept_store #(
  parameter int ENTRIES = 8,
  parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [IDX_W-1:0]    wr_addr,
  input  cept_pkg::entry_t    wr_data,
  input  logic [IDX_W-1:0]    rd_addr,
  output cept_pkg::entry_t    rd_data
);

  cept_pkg::entry_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

### src/cept_ctrl.sv
`timescale 1ns / 1ps

module cept_ctrl #(
  parameter int ENTRIES = 8,
  parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          op,
  input  logic [7:0]          slot_id,
  input  logic [4:0]          endpoint_index,
  input  logic [63:0]         trb_address,
  input  logic [7:0]          completion_code,
  input  logic [23:0]         residue,
  output logic                res_valid,
  input  logic                res_ready,
  output cept_pkg::result_t   res,
  output logic                wr_en,
  output logic [IDX_W-1:0]    wr_addr,
  output cept_pkg::entry_t    wr_data,
  output logic [IDX_W-1:0]    rd_addr,
  input  cept_pkg::entry_t    rd_data
);

  localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

  cept_pkg::state_t  state, state_next;
  logic [2:0]        req_op;
  logic [7:0]        req_slot;
  logic [4:0]        req_ep;
  logic [63:0]       req_trb;
  logic [7:0]        req_code;
  logic [23:0]       req_res;
  logic [IDX_W-1:0]  rd_idx;
  logic [IDX_W-1:0]  cmp_idx;
  logic              cmp_live;
  logic              have_free;
  logic [IDX_W-1:0]  free_idx;
  logic [ENTRIES-1:0] valid;
  logic [IDX_W-1:0]  evict_ptr;
  cept_pkg::result_t res_q, res_next;

  logic              in_fire;
  logic              in_scan_op;
  logic              is_slot_op;
  logic              slot_eq, key_eq, cur_valid, hit, scan_end, free_now;
  logic [IDX_W-1:0]  fill_idx;
  logic              res_load, set_v, clr_v, evict_adv;

  assign in_ready   = (state == cept_pkg::ST_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign in_scan_op = (op == cept_pkg::OP_PUT) || (op == cept_pkg::OP_TAKE) ||
                      (op == cept_pkg::OP_DROP_EXACT) || (op == cept_pkg::OP_DROP_SLOT);
  assign is_slot_op = (req_op == cept_pkg::OP_DROP_SLOT);

  assign slot_eq   = (rd_data.slot == req_slot);
  assign key_eq    = slot_eq && (rd_data.endpoint == req_ep) && (rd_data.trb == req_trb);
  assign cur_valid = valid[cmp_idx];
  assign hit       = (state == cept_pkg::ST_SCAN) && cmp_live && cur_valid &&
                     (is_slot_op ? slot_eq : key_eq);
  assign scan_end  = (state == cept_pkg::ST_SCAN) && cmp_live &&
                     ((cmp_idx == LAST) || (hit && !is_slot_op));
  assign free_now  = have_free || !cur_valid;
  assign fill_idx  = have_free ? free_idx : cmp_idx;

  assign rd_addr   = rd_idx;
  assign res_valid = (state == cept_pkg::ST_RESULT);
  assign res       = res_q;

  always_comb begin
    wr_data.slot     = req_slot;
    wr_data.endpoint = req_ep;
    wr_data.trb      = req_trb;
    wr_data.code     = req_code;
    wr_data.residue  = req_res;
  end

  always_comb begin
    state_next             = state;
    wr_en                  = 1'b0;
    wr_addr                = cmp_idx;
    set_v                  = 1'b0;
    clr_v                  = 1'b0;
    evict_adv              = 1'b0;
    res_load               = 1'b0;
    res_next.outcome       = cept_pkg::OUT_NONE;
    res_next.found_code    = '0;
    res_next.found_residue = '0;

    unique case (state)
      cept_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_scan_op) begin
            state_next = cept_pkg::ST_SCAN;
          end else begin
            state_next = cept_pkg::ST_RESULT;
            res_load   = 1'b1;
          end
        end
      end
      cept_pkg::ST_SCAN: begin
        if (is_slot_op) begin
          clr_v = hit;
        end
        if (scan_end) begin
          state_next = cept_pkg::ST_RESULT;
          res_load   = 1'b1;
          if (req_op == cept_pkg::OP_PUT) begin
            wr_en = 1'b1;
            set_v = 1'b1;
            priority if (hit) begin
              res_next.outcome = cept_pkg::OUT_MATCHED;
            end else if (free_now) begin
              wr_addr          = fill_idx;
              res_next.outcome = cept_pkg::OUT_STORED_FREE;
            end else begin
              wr_addr          = evict_ptr;
              evict_adv        = 1'b1;
              res_next.outcome = cept_pkg::OUT_STORED_EVICT;
            end
          end else if (hit && (req_op == cept_pkg::OP_TAKE)) begin
            clr_v                  = 1'b1;
            res_next.outcome       = cept_pkg::OUT_MATCHED;
            res_next.found_code    = rd_data.code;
            res_next.found_residue = rd_data.residue;
          end else if (hit && (req_op == cept_pkg::OP_DROP_EXACT)) begin
            clr_v            = 1'b1;
            res_next.outcome = cept_pkg::OUT_MATCHED;
          end
        end
      end
      cept_pkg::ST_RESULT: begin
        if (res_ready) begin
          state_next = cept_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = cept_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cept_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_live  <= 1'b0;
      have_free <= 1'b0;
      valid     <= '0;
      evict_ptr <= '0;
    end else begin
      if (in_fire) begin
        cmp_live  <= 1'b0;
        have_free <= 1'b0;
        if (op == cept_pkg::OP_CLEAR) begin
          valid     <= '0;
          evict_ptr <= '0;
        end
      end else if (state == cept_pkg::ST_SCAN) begin
        cmp_live <= 1'b1;
        if (cmp_live && !cur_valid && !have_free) begin
          have_free <= 1'b1;
        end
      end
      if (set_v) begin
        valid[wr_addr] <= 1'b1;
      end
      if (clr_v) begin
        valid[cmp_idx] <= 1'b0;
      end
      if (evict_adv) begin
        evict_ptr <= (evict_ptr == LAST) ? '0 : evict_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_op   <= op;
      req_slot <= slot_id;
      req_ep   <= endpoint_index;
      req_trb  <= trb_address;
      req_code <= completion_code;
      req_res  <= residue;
      rd_idx   <= '0;
    end else if (state == cept_pkg::ST_SCAN) begin
      cmp_idx <= rd_idx;
      if (rd_idx != LAST) begin
        rd_idx <= rd_idx + 1'b1;
      end
      if (cmp_live && !cur_valid && !have_free) begin
        free_idx <= cmp_idx;
      end
    end
    if (res_load) begin
      res_q <= res_next;
    end
  end

  a_evict_bound: assert property (@(posedge clk) disable iff (rst)
    evict_ptr <= LAST)
    else $error("evict pointer beyond last entry");

  a_put_sets_valid: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> valid[$past(wr_addr)])
    else $error("stored entry not marked valid");

  a_none_is_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.outcome == cept_pkg::OUT_NONE) |->
      (res.found_code == '0) && (res.found_residue == '0))
    else $error("empty result carries data");

  a_no_accept_pending: assert property (@(posedge clk) disable iff (rst)
    in_fire |-> !res_valid)
    else $error("request taken while a result is pending");

endmodule

### src/completion_event_parking_table.sv
`timescale 1ns / 1ps
// Put, take and drop requests scan one entry per cycle through the entry
// memory read port; out_valid rises once the scan ends, sooner when a key
// match ends the scan early; a clear or unused code skips the scan.
// in_ready is low during a scan and until the result enters the output register.
// Reset: synchronous; flags and evict pointer clear at once, no clearing pass.

module completion_event_parking_table #(
  parameter int ENTRIES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  op,
  input  logic [7:0]  slot_id,
  input  logic [4:0]  endpoint_index,
  input  logic [63:0] trb_address,
  input  logic [7:0]  completion_code,
  input  logic [23:0] residue,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  outcome,
  output logic [7:0]  found_code,
  output logic [23:0] found_residue
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic              res_valid, res_ready;
  cept_pkg::result_t res;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr, rd_addr;
  cept_pkg::entry_t  wr_data, rd_data;

  cept_store #(.ENTRIES(ENTRIES), .IDX_W(IDX_W)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  cept_ctrl #(.ENTRIES(ENTRIES), .IDX_W(IDX_W)) u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .op              (op),
    .slot_id         (slot_id),
    .endpoint_index  (endpoint_index),
    .trb_address     (trb_address),
    .completion_code (completion_code),
    .residue         (residue),
    .res_valid       (res_valid),
    .res_ready       (res_ready),
    .res             (res),
    .wr_en           (wr_en),
    .wr_addr         (wr_addr),
    .wr_data         (wr_data),
    .rd_addr         (rd_addr),
    .rd_data         (rd_data)
  );

  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      outcome       <= res.outcome;
      found_code    <= res.found_code;
      found_residue <= res.found_residue;
    end
  end

endmodule
